FILE: hdl/axis_angle_vector_rotator_assert.svh
// assertion macros shared by the rotator rtl
`ifndef AXIS_ANGLE_VECTOR_ROTATOR_ASSERT_SVH
`define AXIS_ANGLE_VECTOR_ROTATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define AAVR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define AAVR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/aavr_pkg.sv
// shared types, constants and tables of the axis-angle vector rotator
`timescale 1ns / 1ps
`default_nettype none
package aavr_pkg;

  localparam int VECTOR_WIDTH = 16;
  localparam int OUT_WIDTH    = VECTOR_WIDTH + 1;
  localparam int ENTRY_WIDTH  = 18;
  localparam int AXIS_WIDTH   = 16;
  localparam int CFG_IDX_W    = 8;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CW           = 34;  // cordic x, y, z width

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE  = 8'd3;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [ENTRY_WIDTH-1:0] ENTRY_ONE = 18'sd65536;

  typedef logic signed [ENTRY_WIDTH-1:0] entry_t;
  typedef entry_t [8:0] mat_t;

  // atan(2^-i), binary angle with 2^31 = pi
  function automatic logic signed [CW-1:0] atan_val(input logic [4:0] i);
    logic signed [CW-1:0] r;
    case (i)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10680862;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // axis component by index
  function automatic logic signed [AXIS_WIDTH-1:0] axis_sel(
    input logic [1:0] k,
    input logic signed [AXIS_WIDTH-1:0] a0,
    input logic signed [AXIS_WIDTH-1:0] a1,
    input logic signed [AXIS_WIDTH-1:0] a2
  );
    logic signed [AXIS_WIDTH-1:0] r;
    case (k)
      2'd0:    r = a0;
      2'd1:    r = a1;
      default: r = a2;
    endcase
    return r;
  endfunction

  // skew part of the matrix: which axis component feeds row, col
  function automatic logic [1:0] skew_idx(input logic [1:0] ri, input logic [1:0] cj);
    logic [1:0] r;
    case ({ri, cj})
      4'b0001, 4'b0100: r = 2'd2;
      4'b0010, 4'b1000: r = 2'd1;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  // skew part sign: high means negated
  function automatic logic skew_neg(input logic [1:0] ri, input logic [1:0] cj);
    logic r;
    case ({ri, cj})
      4'b0001, 4'b0110, 4'b1000: r = 1'b1;
      default:                   r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/aavr_if.sv
// request channel interfaces of the rotator: vectors in, results out, config writes
`timescale 1ns / 1ps
`default_nettype none
interface aavr_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic signed [aavr_pkg::VECTOR_WIDTH-1:0] vec_x;
  logic signed [aavr_pkg::VECTOR_WIDTH-1:0] vec_y;
  logic signed [aavr_pkg::VECTOR_WIDTH-1:0] vec_z;
  modport source (output valid, cmd, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, cmd, vec_x, vec_y, vec_z, output ready);
endinterface

interface aavr_out_if;
  logic valid;
  logic ready;
  logic signed [aavr_pkg::OUT_WIDTH-1:0] out_x;
  logic signed [aavr_pkg::OUT_WIDTH-1:0] out_y;
  logic signed [aavr_pkg::OUT_WIDTH-1:0] out_z;
  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

interface aavr_cfg_if;
  logic valid;
  logic ready;
  logic [aavr_pkg::CFG_IDX_W-1:0] index;
  logic [aavr_pkg::AXIS_WIDTH-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/aavr_mat_builder.sv
// config registers, cordic and sequential rodrigues matrix build
`timescale 1ns / 1ps
`default_nettype none
module aavr_mat_builder (
  input  wire logic          clk,
  input  wire logic          rst_n,
  aavr_cfg_if.sink           cfg_ch,
  output aavr_pkg::mat_t     mat,
  output logic               busy
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROT, ST_E0, ST_E1, ST_E2, ST_E3, ST_E4
  } state_t;

  state_t state_r;
  logic signed [aavr_pkg::AXIS_WIDTH-1:0] ax_r, ay_r, az_r, ang_r;
  aavr_pkg::mat_t mat_r;
  logic signed [aavr_pkg::CW-1:0] x_r, y_r, z_r, c_r, s_r;
  logic flip_r;
  logic [aavr_pkg::STEP_W-1:0] cnt_r;
  logic [1:0] ri_r, cj_r;
  logic [3:0] ent_r;
  logic signed [31:0] aa_r;
  logic signed [50:0] p1_r;
  logic signed [48:0] p2_r;
  logic signed [71:0] t_r;

  logic cfg_go;
  logic signed [16:0] ang_w, ang_f;
  logic flip_f;
  logic signed [aavr_pkg::CW-1:0] dx, dy, x_nxt, y_nxt, z_nxt, at;
  logic signed [34:0] omc;
  logic signed [18:0] oh;
  logic [15:0] ol;
  logic signed [15:0] ai, aj, ak;
  logic signed [49:0] ks;
  logic signed [71:0] sum;
  logic signed [27:0] rnd;
  aavr_pkg::entry_t ent_val;

  assign busy         = (state_r != ST_IDLE);
  assign cfg_ch.ready = !busy;
  assign cfg_go       = cfg_ch.valid && cfg_ch.ready;
  assign mat          = mat_r;

  // fold angle into the right half plane
  always_comb begin
    ang_w  = {ang_r[15], ang_r};
    ang_f  = ang_w;
    flip_f = 1'b0;
    if (ang_r > 16'sd16384) begin
      ang_f  = ang_w - 17'sd32768;
      flip_f = 1'b1;
    end else if (ang_r < -16'sd16384) begin
      ang_f  = ang_w + 17'sd32768;
      flip_f = 1'b1;
    end
  end

  // one cordic micro-rotation
  always_comb begin
    dx = x_r >>> cnt_r;
    dy = y_r >>> cnt_r;
    at = aavr_pkg::atan_val(5'(cnt_r));
    if (!z_r[aavr_pkg::CW-1]) begin
      x_nxt = x_r - dy;
      y_nxt = y_r + dx;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + dy;
      y_nxt = y_r - dx;
      z_nxt = z_r + at;
    end
  end

  // entry terms
  always_comb begin
    omc = (35'sd1 <<< 30) - 35'(c_r);
    oh  = omc[34:16];
    ol  = omc[15:0];
    ai  = aavr_pkg::axis_sel(ri_r, ax_r, ay_r, az_r);
    aj  = aavr_pkg::axis_sel(cj_r, ax_r, ay_r, az_r);
    ak  = aavr_pkg::axis_sel(aavr_pkg::skew_idx(ri_r, cj_r), ax_r, ay_r, az_r);
    ks  = 50'(ak) * 50'(s_r);
    sum = (72'(p1_r) <<< 16) + 72'(p2_r) + t_r + (72'sd1 <<< 43);
    rnd = sum[71:44];
    if (rnd > 28'sd131071)       ent_val = 18'sd131071;
    else if (rnd < -28'sd131072) ent_val = -18'sd131072;
    else                         ent_val = rnd[17:0];
  end

  // state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ax_r    <= '0;
      ay_r    <= '0;
      az_r    <= 16'sd32767;
      ang_r   <= '0;
      for (int k = 0; k < 9; k++) begin
        mat_r[k] <= (k % 4 == 0) ? aavr_pkg::ENTRY_ONE : '0;
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cfg_go) begin
            unique case (cfg_ch.index)
              aavr_pkg::REG_AXIS_X: begin ax_r  <= cfg_ch.data; state_r <= ST_LOAD; end
              aavr_pkg::REG_AXIS_Y: begin ay_r  <= cfg_ch.data; state_r <= ST_LOAD; end
              aavr_pkg::REG_AXIS_Z: begin az_r  <= cfg_ch.data; state_r <= ST_LOAD; end
              aavr_pkg::REG_ANGLE:  begin ang_r <= cfg_ch.data; state_r <= ST_LOAD; end
              default: ;
            endcase
          end
        end
        ST_LOAD: begin
          x_r     <= aavr_pkg::CORDIC_GAIN;
          y_r     <= '0;
          z_r     <= {ang_f[16], ang_f, 16'b0};
          flip_r  <= flip_f;
          cnt_r   <= '0;
          state_r <= ST_ROT;
        end
        ST_ROT: begin
          x_r   <= x_nxt;
          y_r   <= y_nxt;
          z_r   <= z_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == aavr_pkg::STEP_W'(aavr_pkg::CORDIC_STEPS - 1)) begin
            c_r     <= flip_r ? -x_nxt : x_nxt;
            s_r     <= flip_r ? -y_nxt : y_nxt;
            ri_r    <= '0;
            cj_r    <= '0;
            ent_r   <= '0;
            state_r <= ST_E0;
          end
        end
        ST_E0: begin
          aa_r    <= 32'(ai) * 32'(aj);
          state_r <= ST_E1;
        end
        ST_E1: begin
          p1_r    <= 51'(aa_r) * 51'(oh);
          state_r <= ST_E2;
        end
        ST_E2: begin
          p2_r    <= 49'(aa_r) * $signed({33'b0, ol});
          state_r <= ST_E3;
        end
        ST_E3: begin
          if (ri_r == cj_r) t_r <= 72'(c_r) <<< 30;
          else if (aavr_pkg::skew_neg(ri_r, cj_r)) t_r <= -(72'(ks) <<< 15);
          else t_r <= 72'(ks) <<< 15;
          state_r <= ST_E4;
        end
        ST_E4: begin
          mat_r[ent_r] <= ent_val;
          ent_r        <= ent_r + 1'b1;
          if (cj_r == 2'd2) begin
            cj_r <= '0;
            ri_r <= ri_r + 1'b1;
          end else begin
            cj_r <= cj_r + 1'b1;
          end
          state_r <= (ent_r == 4'd8) ? ST_IDLE : ST_E0;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/aavr_mul_pipe.sv
// three-stage matrix times vector pipeline with per-stage flow control
`timescale 1ns / 1ps
`default_nettype none
module aavr_mul_pipe (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire aavr_pkg::mat_t mat,
  input  wire logic          hold,
  aavr_in_if.sink            in_ch,
  aavr_out_if.source         out_ch
);

  localparam int VW = aavr_pkg::VECTOR_WIDTH;
  localparam int PW = aavr_pkg::ENTRY_WIDTH + VW;
  localparam int AW = PW + 2;

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  logic cmd1_r;
  logic signed [VW-1:0] vec1_r [3];
  logic signed [PW-1:0] prod_r [9];
  logic signed [PW-1:0] prod_nxt [9];
  logic signed [aavr_pkg::OUT_WIDTH-1:0] res_r [3];
  logic signed [aavr_pkg::OUT_WIDTH-1:0] res_nxt [3];
  logic signed [AW-1:0] acc [3];
  logic signed [AW-17:0] sh [3];

  // stage handshakes
  assign rdy3        = !v3_r || out_ch.ready;
  assign rdy2        = !v2_r || rdy3;
  assign rdy1        = !v1_r || rdy2;
  assign in_ch.ready = rdy1 && !hold;

  assign out_ch.valid = v3_r;
  assign out_ch.out_x = res_r[0];
  assign out_ch.out_y = res_r[1];
  assign out_ch.out_z = res_r[2];

  // products, transposed for backward requests
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i*3+j] = PW'(cmd1_r ? mat[j*3+i] : mat[i*3+j]) * PW'(vec1_r[j]);
      end
    end
  end

  // row sums, round half up, saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = AW'(prod_r[i*3]) + AW'(prod_r[i*3+1]) + AW'(prod_r[i*3+2])
             + AW'(32768);
      sh[i]  = acc[i][AW-1:16];
      if (sh[i] > (AW-16)'((1 <<< VW) - 1))   res_nxt[i] = {1'b0, {VW{1'b1}}};
      else if (sh[i] < -(AW-16)'(1 <<< VW))   res_nxt[i] = {1'b1, {VW{1'b0}}};
      else                                    res_nxt[i] = sh[i][VW:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid && in_ch.ready;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rdy1) begin
      cmd1_r    <= in_ch.cmd;
      vec1_r[0] <= in_ch.vec_x;
      vec1_r[1] <= in_ch.vec_y;
      vec1_r[2] <= in_ch.vec_z;
    end
    if (rdy2) prod_r <= prod_nxt;
    if (rdy3) res_r <= res_nxt;
  end

endmodule
`default_nettype wire

FILE: hdl/axis_angle_vector_rotator.sv
// top level of the axis-angle vector rotator
// Rotates one vector per clock about the configured unit axis by the configured angle,
// unless the output stalls or a matrix build holds requests off, through a three-stage
// pipeline (input register, nine 18x16 products, row sums with round and saturate),
// whose input, product and result registers a request passes in turn. Bit 0 of cmd
// selects the inverse (transposed) rotation. Each write to one of the four registers
// rebuilds the matrix: a load, 16 cordic steps and a multiply-add sequence for each of
// the 9 entries, during which requests and further writes are held off. The axis must
// already be normalized; after reset the matrix is the identity.
`timescale 1ns / 1ps
`default_nettype none
`include "axis_angle_vector_rotator_assert.svh"
module axis_angle_vector_rotator (
  input  wire logic  clk,
  input  wire logic  rst_n,
  aavr_in_if.sink    in_ch,
  aavr_out_if.source out_ch,
  aavr_cfg_if.sink   cfg_ch
);

  aavr_pkg::mat_t mat;
  logic busy;
  logic in_acc;
  logic cfg_acc;
  logic cfg_build;

  // handshake terms for the checks
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign cfg_acc   = cfg_ch.valid && cfg_ch.ready;
  assign cfg_build = cfg_acc && (cfg_ch.index <= aavr_pkg::REG_ANGLE);

  // matrix build from config
  aavr_mat_builder u_build (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .mat    (mat),
    .busy   (busy)
  );

  // vector datapath
  aavr_mul_pipe u_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .mat    (mat),
    .hold   (busy),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  `AAVR_ASSERT_IMP(a_no_req_in_build, in_acc, !busy, "request during build")
  `AAVR_ASSERT_NXT(a_write_starts_build, cfg_build, busy, "write did not start build")
  `AAVR_ASSERT_NXT(a_mat_idle_stable, !busy && !cfg_acc, $stable(mat), "matrix changed while idle")

endmodule
`default_nettype wire
